@@ hdl/tccs_pkg.sv @@
package tccs_pkg;

	localparam int REQ_W  = 3;
	localparam int CHAR_W = 8;
	localparam int ROW_FW = 5;
	localparam int COL_FW = 7;

	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUT   = 3'd0,
		REQ_UP    = 3'd1,
		REQ_DOWN  = 3'd2,
		REQ_RIGHT = 3'd3,
		REQ_LEFT  = 3'd4,
		REQ_HOME  = 3'd5,
		REQ_CLEAR = 3'd6,
		REQ_READ  = 3'd7
	} req_e_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic sweep;
		logic exec;
		logic rd_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_put;
		logic is_read;
		logic row_clean;
		logic sweep_last;
		logic out_free;
	} status_t;

endpackage

@@ hdl/tccs_if.sv @@
interface tccs_req_if
	import tccs_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [CHAR_W-1:0] char_code;
	logic [ROW_FW-1:0] read_row;
	logic [COL_FW-1:0] read_col;

	modport source (output valid, req_type, char_code, read_row, read_col, input ready);
	modport sink (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface tccs_rsp_if
	import tccs_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [ROW_FW-1:0] cursor_row;
	logic [COL_FW-1:0] cursor_col;
	logic              scrolled;
	logic [CHAR_W-1:0] cell_char;

	modport source (output valid, cursor_row, cursor_col, scrolled, cell_char, input ready);
	modport sink (input valid, cursor_row, cursor_col, scrolled, cell_char, output ready);
endinterface

@@ hdl/text_console_cursor_scroll_core.sv @@
// Text console with cursor and scroll, SCREEN_ROWS x SCREEN_COLUMNS bytes.
// req channel: one beat per request (put char, cursor moves, column home,
// clear screen, read cell). rsp channel: exactly one beat per request with
// the cursor after the request, a scrolled flag and the read byte.
// Flow: a request is taken in S_IDLE and executed in S_EXEC; moves, home,
// clear and puts there wait for a free output register, while a read cell
// hands its byte out from S_FIN (registered read of the screen memory). The
// first put into a row that is still blank after reset, a clear or a scroll
// first sweeps spaces across every column of that row through the single
// memory write port. Scrolling moves no bytes: it rotates a row offset.
// Reset: cursor to row 0 column 0, every row marked blank; no clearing pass,
// a request can be taken as soon as reset is released.
// Stall: the response sits in an output register; the next request is
// accepted while it waits, and execution (a read: its output step) holds until the register frees.
module text_console_cursor_scroll_core
	import tccs_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	tccs_req_if.sink   req,
	tccs_rsp_if.source rsp
);

	cmd_t    cmd;
	status_t st;

	tccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	tccs_dp #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.req_type   (req.req_type),
		.char_code  (req.char_code),
		.read_row   (req.read_row),
		.read_col   (req.read_col),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.cursor_row (rsp.cursor_row),
		.cursor_col (rsp.cursor_col),
		.scrolled   (rsp.scrolled),
		.cell_char  (rsp.cell_char)
	);

endmodule

@@ hdl/tccs_ctrl.sv @@
module tccs_ctrl
	import tccs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_EXEC;
				end
			end
			S_EXEC: begin
				// a put into a row not yet blanked clears that row first
				if (st.is_put && !st.row_clean) begin
					state_nxt = S_SWEEP;
				end else if (st.is_read) begin
					cmd.exec  = 1'b1;
					state_nxt = S_FIN;
				end else if (st.out_free) begin
					cmd.exec  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (st.sweep_last) begin
					state_nxt = S_EXEC;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.rd_out = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hdl/tccs_dp.sv @@
module tccs_dp
	import tccs_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           st,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ROW_FW-1:0] read_row,
	input  logic [COL_FW-1:0] read_col,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROW_FW-1:0] cursor_row,
	output logic [COL_FW-1:0] cursor_col,
	output logic              scrolled,
	output logic [CHAR_W-1:0] cell_char
);

	localparam int CW    = $clog2(SCREEN_COLUMNS);
	localparam int RW    = $clog2(SCREEN_ROWS);
	localparam int DEPTH = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [CW-1:0] COL_LAST = CW'(SCREEN_COLUMNS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_ROWS - 1);

	// latched request
	req_e_t            req_q;
	logic [CHAR_W-1:0] char_q;
	logic [ROW_FW-1:0] rrow_q;
	logic [COL_FW-1:0] rcol_q;

	// cursor, top-of-screen row in the store, per-row blanked flags
	logic [RW-1:0]          row_q;
	logic [CW-1:0]          col_q;
	logic [RW-1:0]          top_q;
	logic [SCREEN_ROWS-1:0] rv_q;
	logic [CW-1:0]          sw_q;

	logic [CHAR_W-1:0] mem [DEPTH];
	logic [CHAR_W-1:0] rdata_q;
	logic              rd_inr_q;
	logic              rd_vld_q;

	logic              out_valid_q;
	logic [ROW_FW-1:0] o_row_q;
	logic [COL_FW-1:0] o_col_q;
	logic              o_scr_q;
	logic [CHAR_W-1:0] o_cell_q;

	logic          is_put;
	logic          is_read;
	logic          rd_inr;
	logic [RW-1:0] lrow;
	logic [CW-1:0] col_sel;
	logic [RW:0]   row_sum;
	logic [RW-1:0] phys;
	logic [AW-1:0] addr;
	logic          we;
	logic          out_free;

	logic [RW-1:0] row_nxt;
	logic [CW-1:0] col_nxt;
	logic [RW-1:0] top_nxt;
	logic          scr_nxt;
	logic          do_clear;

	assign is_put  = (req_q == REQ_PUT);
	assign is_read = (req_q == REQ_READ);
	assign rd_inr  = (32'(rrow_q) < 32'(SCREEN_ROWS)) && (32'(rcol_q) < 32'(SCREEN_COLUMNS));

	// logical row -> store row, rotated by the scroll offset
	assign lrow    = is_read ? (rd_inr ? RW'(rrow_q) : '0) : row_q;
	assign col_sel = cmd.sweep ? sw_q : (is_read ? (rd_inr ? CW'(rcol_q) : '0) : col_q);
	assign row_sum = {1'b0, lrow} + {1'b0, top_q};
	assign phys    = (row_sum >= (RW+1)'(SCREEN_ROWS)) ?
		RW'(row_sum - (RW+1)'(SCREEN_ROWS)) : RW'(row_sum);
	assign addr    = AW'(phys) * AW'(SCREEN_COLUMNS) + AW'(col_sel);
	assign we      = cmd.sweep || (cmd.exec && is_put);

	assign out_free = !out_valid_q || out_ready;

	assign st.is_put     = is_put;
	assign st.is_read    = is_read;
	assign st.row_clean  = rv_q[phys];
	assign st.sweep_last = (sw_q == COL_LAST);
	assign st.out_free   = out_free;

	always_comb begin
		row_nxt  = row_q;
		col_nxt  = col_q;
		top_nxt  = top_q;
		scr_nxt  = 1'b0;
		do_clear = 1'b0;
		case (req_q)
			REQ_PUT: begin
				if (col_q == COL_LAST) begin
					col_nxt = '0;
					if (row_q == ROW_LAST) begin
						scr_nxt = 1'b1;
						top_nxt = (top_q == ROW_LAST) ? '0 : top_q + 1'b1;
					end else begin
						row_nxt = row_q + 1'b1;
					end
				end else begin
					col_nxt = col_q + 1'b1;
				end
			end
			REQ_UP:    if (row_q != '0) row_nxt = row_q - 1'b1;
			REQ_DOWN:  if (row_q != ROW_LAST) row_nxt = row_q + 1'b1;
			REQ_RIGHT: if (col_q != COL_LAST) col_nxt = col_q + 1'b1;
			REQ_LEFT:  if (col_q != '0) col_nxt = col_q - 1'b1;
			REQ_HOME:  col_nxt = '0;
			REQ_CLEAR: begin
				row_nxt  = '0;
				col_nxt  = '0;
				top_nxt  = '0;
				do_clear = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= req_e_t'(req_type);
			char_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_col;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= cmd.sweep ? BLANK_CHAR : char_q;
		end
		if (cmd.exec && is_read) begin
			rdata_q  <= mem[addr];
			rd_inr_q <= rd_inr;
			rd_vld_q <= rv_q[phys];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			top_q <= '0;
			rv_q  <= '0;
			sw_q  <= '0;
		end else begin
			if (cmd.sweep) begin
				sw_q <= st.sweep_last ? '0 : sw_q + 1'b1;
				if (st.sweep_last) begin
					rv_q[phys] <= 1'b1;
				end
			end
			if (cmd.exec && !is_read) begin
				row_q <= row_nxt;
				col_q <= col_nxt;
				top_q <= top_nxt;
				if (do_clear) begin
					rv_q <= '0;
				end else if (scr_nxt) begin
					// old top row becomes the new bottom row, blank again
					rv_q[top_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.exec && !is_read) || cmd.rd_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !is_read) begin
			o_row_q  <= ROW_FW'(row_nxt);
			o_col_q  <= COL_FW'(col_nxt);
			o_scr_q  <= scr_nxt;
			o_cell_q <= '0;
		end else if (cmd.rd_out) begin
			o_row_q  <= ROW_FW'(row_q);
			o_col_q  <= COL_FW'(col_q);
			o_scr_q  <= 1'b0;
			o_cell_q <= rd_inr_q ? (rd_vld_q ? rdata_q : BLANK_CHAR) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_row = o_row_q;
	assign cursor_col = o_col_q;
	assign scrolled   = o_scr_q;
	assign cell_char  = o_cell_q;

endmodule
